[rtl/timed_repeat_event_table_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the timed repeat event table
// Shared concurrent-assertion wrappers; clocked on clk, disabled in rst.
// ---------------------------------------------------------------------------
`ifndef TIMED_REPEAT_EVENT_TABLE_TOP_MACROS_SVH
`define TIMED_REPEAT_EVENT_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define TREVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TREVT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/trevt_pkg.sv]
// ---------------------------------------------------------------------------
// trevt_pkg
// Shared types and constants of the timed repeat event table.
// ---------------------------------------------------------------------------
package trevt_pkg;

  // command codes
  typedef enum logic {
    CMD_REGISTER = 1'b0,
    CMD_CLEAR    = 1'b1
  } cmd_t;

  // config port
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;
  localparam int WINDOW_BITS = 16;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd350;

  // register index (byte address / 4)
  localparam logic [ADDR_BITS-3:0] REG_REPEAT_WINDOW = 1'b0;

  // control flags carried by the search packet along the chain
  typedef struct packed {
    logic active;      // packet holds a live lookup
    logic found;       // id matched a valid slot
    logic free_found;  // an invalid slot was passed before any match
  } scan_flags_t;

endpackage

[rtl/trevt_cell.sv]
// ---------------------------------------------------------------------------
// trevt_cell
// One table slot plus one stage of the search packet that walks the chain.
// ---------------------------------------------------------------------------
module trevt_cell
  import trevt_pkg::*;
#(
  parameter int ID_BITS    = 16,
  parameter int TIME_BITS  = 32,
  parameter int IDX_BITS   = 6,
  parameter int CELL_INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic clr,
  input  logic wr_en,
  input  logic [IDX_BITS-1:0]  wr_idx,
  input  logic [ID_BITS-1:0]   wr_id,
  input  logic [TIME_BITS-1:0] wr_stamp,
  input  logic [ID_BITS+3*TIME_BITS+3*IDX_BITS+3-1:0] pkt_in,
  output logic [ID_BITS+3*TIME_BITS+3*IDX_BITS+3-1:0] pkt_out,
  output logic valid
);

  typedef struct packed {
    scan_flags_t           flags;
    logic [ID_BITS-1:0]    id;
    logic [TIME_BITS-1:0]  now;
    logic [IDX_BITS-1:0]   match_idx;
    logic [TIME_BITS-1:0]  match_stamp;
    logic [IDX_BITS-1:0]   free_idx;
    logic [TIME_BITS-1:0]  oldest_stamp;
    logic [IDX_BITS-1:0]   oldest_idx;
  } pkt_t;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

  logic [ID_BITS-1:0]   slot_id;
  logic [TIME_BITS-1:0] slot_stamp;
  logic                 slot_valid;
  pkt_t                 pin;
  pkt_t                 pkt_next;
  pkt_t                 pkt;

  assign pin     = pkt_in;
  assign pkt_out = pkt;
  assign valid   = slot_valid;

  // lowest match wins; free slot freezes the oldest search
  always_comb begin
    pkt_next = pin;
    if (pin.flags.active && !pin.flags.found) begin
      if (slot_valid && (slot_id == pin.id)) begin
        pkt_next.flags.found = 1'b1;
        pkt_next.match_idx   = MY_IDX;
        pkt_next.match_stamp = slot_stamp;
      end else if (!pin.flags.free_found) begin
        if (!slot_valid) begin
          pkt_next.flags.free_found = 1'b1;
          pkt_next.free_idx         = MY_IDX;
        end else if (slot_stamp < pin.oldest_stamp) begin
          pkt_next.oldest_stamp = slot_stamp;
          pkt_next.oldest_idx   = MY_IDX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pkt.id           <= pkt_next.id;
    pkt.now          <= pkt_next.now;
    pkt.match_idx    <= pkt_next.match_idx;
    pkt.match_stamp  <= pkt_next.match_stamp;
    pkt.free_idx     <= pkt_next.free_idx;
    pkt.oldest_stamp <= pkt_next.oldest_stamp;
    pkt.oldest_idx   <= pkt_next.oldest_idx;
    if (rst) begin
      pkt.flags <= '0;
    end else begin
      pkt.flags <= pkt_next.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      slot_id    <= wr_id;
      slot_stamp <= wr_stamp;
    end
    if (rst || clr) begin
      slot_valid <= 1'b0;
    end else if (wr_en && (wr_idx == MY_IDX)) begin
      slot_valid <= 1'b1;
    end
  end

endmodule

[rtl/timed_repeat_event_table_top.sv]
// ---------------------------------------------------------------------------
// timed_repeat_event_table_top
// Per-target repeat (double-click) detector over a table of id/stamp slots.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | input     | in_valid / in_ready | cmd, tgt_id, hit,
//          |           |                     | button_pressed, now_ms
//  out     | output    | out_valid/out_ready | repeat_detected
//  cfg     | input     | APB psel/penable    | repeat_window at byte address 0
//
//  A register event walks a search packet through the cell chain, one cell
//  per cycle, so the chain length sets the time from accept to the next
//  accept. Clear commands and unarmed events skip the scan and go
//  straight from the idle state to the finish state.
//  rst clears all valid bits at once; no clearing pass is needed.
//  A result waiting in the output register does not block the next input
//  transaction; only a second finished result waits for out_ready.
// ---------------------------------------------------------------------------
`include "timed_repeat_event_table_top_macros.svh"

module timed_repeat_event_table_top
  import trevt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 16,
  parameter int TIME_BITS     = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [ID_BITS-1:0]    tgt_id,
  input  logic                  hit,
  input  logic                  button_pressed,
  input  logic [TIME_BITS-1:0]  now_ms,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  repeat_detected,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int PKT_BITS = ID_BITS + 3*TIME_BITS + 3*IDX_BITS + 3;

  // search packet: same layout as in the cells
  typedef struct packed {
    scan_flags_t           flags;
    logic [ID_BITS-1:0]    id;
    logic [TIME_BITS-1:0]  now;
    logic [IDX_BITS-1:0]   match_idx;
    logic [TIME_BITS-1:0]  match_stamp;
    logic [IDX_BITS-1:0]   free_idx;
    logic [TIME_BITS-1:0]  oldest_stamp;
    logic [IDX_BITS-1:0]   oldest_idx;
  } pkt_t;

  // write-back broadcast to the cells
  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   idx;
    logic [ID_BITS-1:0]    id;
    logic [TIME_BITS-1:0]  stamp;
  } wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                 state;
  logic                   pend_rep;
  logic [WINDOW_BITS-1:0] repeat_window;

  logic                   in_xact;
  logic                   armed;
  logic                   clr;
  pkt_t                   inj;
  pkt_t                   chain [TABLE_ENTRIES+1];
  pkt_t                   last;
  wr_t                    wr;
  logic [TIME_BITS-1:0]   diff;
  logic                   rep_calc;
  logic [TABLE_ENTRIES-1:0] act_vec;
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic                   cfg_wr;
  logic [ADDR_BITS-3:0]   cfg_idx;

  // -------------------------------------------------------------------------
  // Input side: the block takes a transaction only when no lookup is in flight
  // -------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE) && !rst;
  assign in_xact  = in_valid && in_ready;
  assign armed    = (cmd == CMD_REGISTER) && hit && button_pressed;
  assign clr      = in_xact && (cmd == CMD_CLEAR);

  // Fresh packet: oldest candidate starts at now, index 0, which gives the
  // "no stamp older than now -> slot 0" fallback for free.
  always_comb begin
    inj                  = '0;
    inj.flags.active     = in_xact && armed;
    inj.id               = tgt_id;
    inj.now              = now_ms;
    inj.oldest_stamp     = now_ms;
    inj.oldest_idx       = '0;
  end

  assign chain[0] = inj;

  // -------------------------------------------------------------------------
  // Cell chain: one slot per cell, packet advances one cell per cycle
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [PKT_BITS-1:0] p_out;

    trevt_cell #(
      .ID_BITS    (ID_BITS),
      .TIME_BITS  (TIME_BITS),
      .IDX_BITS   (IDX_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (clr),
      .wr_en    (wr.en),
      .wr_idx   (wr.idx),
      .wr_id    (wr.id),
      .wr_stamp (wr.stamp),
      .pkt_in   (chain[i]),
      .pkt_out  (p_out),
      .valid    (valid_vec[i])
    );

    assign chain[i+1]  = p_out;
    assign act_vec[i]  = chain[i+1].flags.active;
  end

  assign last = chain[TABLE_ENTRIES];

  // -------------------------------------------------------------------------
  // Write-back: the packet leaving the last cell picks the slot to update.
  // Match -> matched slot; else first free slot; else oldest (or slot 0).
  // -------------------------------------------------------------------------
  always_comb begin
    wr       = '0;
    wr.id    = last.id;
    wr.stamp = last.now;
    wr.en    = (state == S_SCAN) && last.flags.active;
    if (last.flags.found) begin
      wr.idx = last.match_idx;
    end else if (last.flags.free_found) begin
      wr.idx = last.free_idx;
    end else begin
      wr.idx = last.oldest_idx;
    end
  end

  // repeat: time went backwards, or elapsed time fits the window
  assign diff     = last.now - last.match_stamp;
  assign rep_calc = last.flags.found &&
                    ((last.now <= last.match_stamp) ||
                     (diff <= TIME_BITS'(repeat_window)));

  // -------------------------------------------------------------------------
  // Control and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pend_rep        <= 1'b0;
      out_valid       <= 1'b0;
      repeat_detected <= 1'b0;
    end else begin
      // S_FINISH reloads the output register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xact) begin
            pend_rep <= 1'b0;
            // clear and unarmed events finish at once with no repeat
            state    <= armed ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (last.flags.active) begin
            pend_rep <= rep_calc;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hand over to the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            repeat_detected <= pend_rep;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (cfg_idx == REG_REPEAT_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_window <= WINDOW_RESET;
    end else if (cfg_wr) begin
      repeat_window <= pwdata[WINDOW_BITS-1:0];
    end
  end

  assign prdata = (cfg_idx == REG_REPEAT_WINDOW) ? DATA_BITS'(repeat_window)
                                                 : '0;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `TREVT_ASSERT_IMP(a_one_packet, 1'b1, $countones(act_vec) <= 1, "more than one packet in chain")
  `TREVT_ASSERT_IMP(a_wr_in_scan, wr.en, state == S_SCAN, "write-back outside scan")
  `TREVT_ASSERT_IMP(a_exit_in_scan, last.flags.active, state == S_SCAN, "packet exit outside scan")
  `TREVT_ASSERT_NXT(a_busy_after_in, in_xact, !in_ready, "ready held high after input")
  `TREVT_ASSERT_NXT(a_clear_empties, clr, valid_vec == '0, "clear left valid slots")

endmodule
